FILE: sv/jcet_pkg.sv
// ============================================================================
// jcet_pkg: shared types and constants of the JSON character event tokenizer
// Parser state codes, event codes, character constants, and the command and
// status records between the controller and the datapath.
// ============================================================================
`default_nettype none

package jcet_pkg;

    localparam int unsigned MAX_DEPTH_DEF = 32;
    localparam int unsigned CHAR_W        = 8;
    localparam int unsigned CODE_W        = 4;
    localparam int unsigned DEPTH_W       = 6;
    localparam int unsigned MAX_EVENTS    = 4;
    localparam int unsigned MAX_STEPS     = 8;
    localparam int unsigned CNT_W         = $clog2(MAX_EVENTS + 1);
    localparam int unsigned IDX_W         = $clog2(MAX_EVENTS);
    localparam int unsigned STEP_W        = $clog2(MAX_STEPS);

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

    typedef enum logic [3:0] {
        PS_SKIP   = 4'd0,
        PS_OPEN   = 4'd1,
        PS_CLOSE  = 4'd2,
        PS_IBEG   = 4'd3,
        PS_IEND   = 4'd4,
        PS_IRET   = 4'd5,
        PS_NQUOT  = 4'd6,
        PS_NBEG   = 4'd7,
        PS_NEND   = 4'd8,
        PS_ASSIGN = 4'd9,
        PS_ABEG   = 4'd10,
        PS_AEND   = 4'd11,
        PS_VQUOT  = 4'd12,
        PS_VBEG   = 4'd13,
        PS_VEND   = 4'd14
    } t_pstate;

    typedef enum logic [1:0] {
        ACT_PAUSE = 2'd0,
        ACT_NEXT  = 2'd1,
        ACT_OK    = 2'd2,
        ACT_FAIL  = 2'd3
    } t_act;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } t_stack_op;

    typedef enum logic [CODE_W-1:0] {
        EV_MEMBER      = 4'd0,
        EV_NAME_CHAR   = 4'd1,
        EV_NAME_DONE   = 4'd2,
        EV_ELEMENT     = 4'd3,
        EV_VALUE_START = 4'd4,
        EV_VALUE_CHAR  = 4'd5,
        EV_VALUE_DONE  = 4'd6,
        EV_ARRAY_MARK  = 4'd7,
        EV_PUSH        = 4'd8,
        EV_POP         = 4'd9,
        EV_OK          = 4'd10,
        EV_FAIL        = 4'd11
    } t_event;

    typedef enum logic [1:0] {
        CS_IDLE  = 2'd0,
        CS_STEP  = 2'd1,
        CS_DRAIN = 2'd2
    } t_ctrl_state;

    typedef struct packed {
        t_event              code;
        logic [CHAR_W-1:0]   ch;
        logic [DEPTH_W-1:0]  depth;
        logic                is_array;
    } t_event_rec;

    typedef struct packed {
        logic              load;
        logic              step;
        logic              drain;
        logic              drain_last;
        logic [IDX_W-1:0]  drain_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic              halted;
        logic              stop;
        logic              out_free;
        logic [CNT_W-1:0]  ev_cnt;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: sv/jcet_if.sv
// ============================================================================
// jcet_if: channel interfaces of the JSON character event tokenizer
// One interface for the character input channel and one for the event output
// channel, each a valid/ready handshake with its payload.
// ============================================================================
`default_nettype none

interface jcet_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       begin_doc;

    modport source (output valid, output char_code, output begin_doc, input ready);
    modport sink   (input valid, input char_code, input begin_doc, output ready);
endinterface

interface jcet_event_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_code;
    logic [7:0] event_char;
    logic [5:0] depth;
    logic       is_array;
    logic       last;

    modport source (output valid, output event_code, output event_char, output depth,
                    output is_array, output last, input ready);
    modport sink   (input valid, input event_code, input event_char, input depth,
                    input is_array, input last, output ready);
endinterface

`default_nettype wire

FILE: sv/jcet_ctrl.sv
// ============================================================================
// jcet_ctrl: sequencing controller of the tokenizer
// Accepts a character, runs the datapath one parser transition per cycle and
// then moves the collected events to the output register one at a time.
// ============================================================================
`default_nettype none

module jcet_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire jcet_pkg::t_dp_sts i_sts,
    output jcet_pkg::t_dp_cmd      o_cmd
);
    import jcet_pkg::*;

    t_ctrl_state       r_state;
    t_ctrl_state       n_state;
    logic [STEP_W-1:0] r_iter;
    logic [CNT_W-1:0]  r_idx;
    logic              w_last_step;
    logic              w_last_ev;

    assign w_last_step = (r_iter == STEP_W'(MAX_STEPS - 1));
    assign w_last_ev   = ((r_idx + CNT_W'(1)) == i_sts.ev_cnt);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE: begin
                if (i_in_valid) begin
                    n_state = CS_STEP;
                end
            end
            CS_STEP: begin
                if (i_sts.halted) begin
                    n_state = CS_IDLE;
                end else if (i_sts.stop || w_last_step) begin
                    n_state = CS_DRAIN;
                end
            end
            CS_DRAIN: begin
                if (i_sts.ev_cnt == '0) begin
                    n_state = CS_IDLE;
                end else if (i_sts.out_free && w_last_ev) begin
                    n_state = CS_IDLE;
                end
            end
            default: n_state = CS_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = (r_state == CS_IDLE);
        o_cmd.load       = (r_state == CS_IDLE) && i_in_valid;
        o_cmd.step       = (r_state == CS_STEP) && !i_sts.halted;
        o_cmd.drain      = (r_state == CS_DRAIN) && (i_sts.ev_cnt != '0) && i_sts.out_free;
        o_cmd.drain_last = w_last_ev;
        o_cmd.drain_idx  = r_idx[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_iter  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_iter <= '0;
                r_idx  <= '0;
            end else begin
                if (o_cmd.step) begin
                    r_iter <= r_iter + STEP_W'(1);
                end
                if (o_cmd.drain) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/jcet_dp.sv
// ============================================================================
// jcet_dp: parser datapath of the tokenizer
// Holds the parser state, the array flag stack memory, the per-character
// event buffer and the output register; evaluates one transition per step.
// ============================================================================
`default_nettype none

module jcet_dp #(
    parameter int unsigned MAX_DEPTH = jcet_pkg::MAX_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire jcet_pkg::t_dp_cmd              i_cmd,
    output jcet_pkg::t_dp_sts                   o_sts,
    input  wire logic [jcet_pkg::CHAR_W-1:0]    i_char_code,
    input  wire logic                           i_begin_doc,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output jcet_pkg::t_event_rec                o_out_rec,
    output logic                                o_out_last
);
    import jcet_pkg::*;

    localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
    localparam int unsigned AW = $clog2(MAX_DEPTH);

    // Parser state.
    t_pstate           r_pstate;
    logic              r_in_array;
    logic              r_item;
    logic [DW-1:0]     r_depth;
    logic              r_halted;
    logic [CHAR_W-1:0] r_char;
    logic [CNT_W-1:0]  r_cnt;

    // Array flag stack and its registered top-of-stack read.
    logic              r_stack [MAX_DEPTH];
    logic              r_top;
    logic [AW-1:0]     w_rd_addr;
    logic [AW-1:0]     w_wr_addr;
    logic              w_we;
    logic [DW-1:0]     w_depth_nx;

    t_event_rec        r_buf [MAX_EVENTS];
    logic              r_out_valid;
    t_event_rec        r_out_rec;
    logic              r_out_last;

    // Transition decode.
    t_pstate           ns;
    t_act              act;
    t_stack_op         op;
    logic              w_space;
    logic              w_endval;

    // Transition effects.
    t_pstate           n_pstate;
    logic              n_in_array;
    logic              n_item;
    logic [DW-1:0]     n_depth;
    logic              n_halted;
    logic              w_ev_valid;
    t_event            w_ev_code;
    logic [CHAR_W-1:0] w_ev_char;
    logic              w_stop;
    logic              w_push;
    t_event_rec        w_rec;

    assign w_space  = (r_char == CH_SPACE) || (r_char == CH_TAB) ||
                      (r_char == CH_LF) || (r_char == CH_CR);
    assign w_endval = (r_char == CH_QUOTE) || (r_char == CH_COMMA) ||
                      (r_char == CH_RBRACK) || (r_char == CH_RBRACE);

    always_comb begin
        ns  = PS_SKIP;
        act = ACT_FAIL;
        op  = OP_NONE;
        unique case (r_pstate)
            PS_SKIP: begin
                if (r_char == CH_LBRACE) begin
                    ns = PS_OPEN; act = ACT_PAUSE;
                end else if (r_char == CH_NUL) begin
                    act = ACT_OK;
                end else begin
                    ns = PS_SKIP; act = ACT_NEXT;
                end
            end
            PS_OPEN: begin
                if (r_char == CH_LBRACE) begin
                    ns = PS_OPEN; act = ACT_NEXT; op = OP_PUSH;
                end else if (w_space) begin
                    ns = PS_OPEN; act = ACT_NEXT;
                end else if (r_char == CH_QUOTE) begin
                    ns = PS_IBEG; act = ACT_PAUSE;
                end
            end
            PS_IBEG: begin
                if (r_char == CH_QUOTE) begin
                    ns = PS_NQUOT; act = ACT_NEXT;
                end
            end
            PS_NQUOT: begin
                ns = PS_NBEG; act = ACT_PAUSE;
            end
            PS_NBEG: begin
                if (r_char == CH_QUOTE) begin
                    ns = PS_NEND; act = ACT_PAUSE;
                end else if (r_char != CH_NUL) begin
                    ns = PS_NBEG; act = ACT_NEXT;
                end
            end
            PS_NEND: begin
                if ((r_char == CH_QUOTE) || w_space) begin
                    ns = PS_NEND; act = ACT_NEXT;
                end else if (r_char == CH_COLON) begin
                    ns = PS_ASSIGN; act = ACT_NEXT;
                end
            end
            PS_ASSIGN: begin
                if (w_space) begin
                    ns = PS_ASSIGN; act = ACT_NEXT;
                end else if (r_char == CH_LBRACE) begin
                    ns = PS_OPEN; act = ACT_PAUSE;
                end else if (r_char == CH_LBRACK) begin
                    ns = PS_ABEG; act = ACT_PAUSE;
                end else if (r_char == CH_QUOTE) begin
                    ns = PS_VQUOT; act = ACT_NEXT;
                end else begin
                    ns = PS_VBEG; act = ACT_PAUSE;
                end
            end
            PS_ABEG: begin
                if ((r_char == CH_LBRACK) || w_space) begin
                    ns = PS_ABEG; act = ACT_NEXT;
                end else if (r_char == CH_LBRACE) begin
                    ns = PS_OPEN; act = ACT_PAUSE;
                end else if (r_char == CH_QUOTE) begin
                    ns = PS_VQUOT; act = ACT_NEXT;
                end else if (w_endval) begin
                    ns = PS_VEND; act = ACT_PAUSE;
                end else begin
                    ns = PS_VBEG; act = ACT_PAUSE;
                end
            end
            PS_VQUOT: begin
                ns = PS_VBEG; act = ACT_PAUSE;
            end
            PS_VBEG: begin
                if (w_endval) begin
                    ns = PS_VEND; act = ACT_PAUSE;
                end else if (r_char != CH_NUL) begin
                    ns = PS_VBEG; act = ACT_NEXT;
                end
            end
            PS_VEND: begin
                if ((r_char == CH_QUOTE) || w_space) begin
                    ns = PS_VEND; act = ACT_NEXT;
                end else if ((r_char == CH_COMMA) || (r_char == CH_RBRACK) ||
                             (r_char == CH_RBRACE)) begin
                    ns = PS_IEND; act = ACT_PAUSE;
                end
            end
            PS_IEND: begin
                if (r_char == CH_COMMA) begin
                    if (r_in_array) begin
                        ns = PS_IRET; act = ACT_PAUSE;
                    end else begin
                        ns = PS_IEND; act = ACT_NEXT;
                    end
                end else if (w_space) begin
                    ns = PS_IEND; act = ACT_NEXT;
                end else if (r_char == CH_QUOTE) begin
                    ns = PS_IBEG; act = ACT_PAUSE;
                end else if (r_char == CH_RBRACK) begin
                    ns = PS_AEND; act = ACT_PAUSE;
                end else if (r_char == CH_RBRACE) begin
                    ns = PS_CLOSE; act = ACT_PAUSE;
                end
            end
            PS_IRET: begin
                if ((r_char == CH_COMMA) || w_space) begin
                    ns = PS_IRET; act = ACT_NEXT;
                end else if (r_char == CH_LBRACE) begin
                    ns = PS_OPEN; act = ACT_PAUSE;
                end else if (r_char == CH_QUOTE) begin
                    ns = PS_VQUOT; act = ACT_NEXT;
                end else begin
                    ns = PS_VBEG; act = ACT_PAUSE;
                end
            end
            PS_AEND: begin
                if ((r_char == CH_RBRACK) || w_space) begin
                    ns = PS_AEND; act = ACT_NEXT;
                end else if ((r_char == CH_COMMA) || (r_char == CH_RBRACE)) begin
                    ns = PS_IEND; act = ACT_PAUSE;
                end
            end
            PS_CLOSE: begin
                if (r_char == CH_RBRACE) begin
                    ns = PS_CLOSE; act = ACT_NEXT; op = OP_POP;
                end else if (w_space) begin
                    ns = PS_CLOSE; act = ACT_NEXT;
                end else if (r_char == CH_RBRACK) begin
                    ns = PS_AEND; act = ACT_PAUSE;
                end else if (r_char == CH_COMMA) begin
                    ns = PS_IEND; act = ACT_PAUSE;
                end else begin
                    ns = PS_SKIP; act = ACT_PAUSE;
                end
            end
            default: begin
                act = ACT_FAIL;
            end
        endcase
    end

    // At most one event comes out of a single transition.
    always_comb begin
        n_pstate   = r_pstate;
        n_in_array = r_in_array;
        n_item     = r_item;
        n_depth    = r_depth;
        n_halted   = r_halted;
        w_ev_valid = 1'b0;
        w_ev_code  = EV_FAIL;
        w_ev_char  = '0;
        w_stop     = 1'b0;
        w_push     = 1'b0;
        if ((act == ACT_OK) || (act == ACT_FAIL)) begin
            w_ev_valid = 1'b1;
            w_ev_code  = (act == ACT_OK) ? EV_OK : EV_FAIL;
            n_halted   = 1'b1;
            w_stop     = 1'b1;
        end else begin
            n_pstate = ns;
            if (act == ACT_PAUSE) begin
                case (ns)
                    PS_ABEG: begin
                        n_in_array = 1'b1;
                        n_item     = 1'b1;
                        w_ev_valid = 1'b1;
                        w_ev_code  = EV_ARRAY_MARK;
                    end
                    PS_AEND: begin
                        n_in_array = 1'b0;
                    end
                    PS_NBEG: begin
                        n_item     = 1'b0;
                        w_ev_valid = 1'b1;
                        w_ev_code  = EV_MEMBER;
                    end
                    PS_IRET: begin
                        n_item     = r_in_array;
                        w_ev_valid = 1'b1;
                        w_ev_code  = EV_ELEMENT;
                    end
                    PS_NEND: begin
                        w_ev_valid = 1'b1;
                        w_ev_code  = EV_NAME_DONE;
                    end
                    PS_VBEG: begin
                        w_ev_valid = 1'b1;
                        w_ev_code  = EV_VALUE_START;
                    end
                    PS_VEND: begin
                        w_ev_valid = 1'b1;
                        w_ev_code  = EV_VALUE_DONE;
                    end
                    default: begin
                    end
                endcase
            end else if (ns == PS_NBEG) begin
                w_ev_valid = 1'b1;
                w_ev_code  = EV_NAME_CHAR;
                w_ev_char  = r_char;
            end else if (ns == PS_VBEG) begin
                w_ev_valid = 1'b1;
                w_ev_code  = EV_VALUE_CHAR;
                w_ev_char  = r_char;
            end

            if (op == OP_PUSH) begin
                w_ev_valid = 1'b1;
                if (r_depth >= DW'(MAX_DEPTH)) begin
                    w_ev_code = EV_FAIL;
                    n_halted  = 1'b1;
                    w_stop    = 1'b1;
                end else begin
                    w_push     = 1'b1;
                    n_depth    = r_depth + DW'(1);
                    n_in_array = 1'b0;
                    w_ev_code  = EV_PUSH;
                end
            end else if (op == OP_POP) begin
                w_ev_valid = 1'b1;
                if (r_depth == '0) begin
                    w_ev_code = EV_FAIL;
                    n_halted  = 1'b1;
                    w_stop    = 1'b1;
                end else begin
                    n_depth    = r_depth - DW'(1);
                    n_in_array = r_top;
                    n_item     = r_top;
                    w_ev_code  = EV_POP;
                end
            end

            if (act == ACT_NEXT) begin
                w_stop = 1'b1;
            end
        end
    end

    assign w_rec.code     = w_ev_code;
    assign w_rec.ch       = w_ev_char;
    assign w_rec.depth    = DEPTH_W'(n_depth);
    assign w_rec.is_array = n_in_array;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pstate   <= PS_SKIP;
            r_in_array <= 1'b0;
            r_item     <= 1'b0;
            r_depth    <= '0;
            r_halted   <= 1'b0;
            r_cnt      <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
            if (i_begin_doc) begin
                r_pstate   <= PS_SKIP;
                r_in_array <= 1'b0;
                r_item     <= 1'b0;
                r_depth    <= '0;
                r_halted   <= 1'b0;
            end
        end else if (i_cmd.step) begin
            r_pstate   <= n_pstate;
            r_in_array <= n_in_array;
            r_item     <= n_item;
            r_depth    <= n_depth;
            r_halted   <= n_halted;
            if (w_ev_valid && (r_cnt < CNT_W'(MAX_EVENTS))) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= i_char_code;
        end
        if (i_cmd.step && w_ev_valid && (r_cnt < CNT_W'(MAX_EVENTS))) begin
            r_buf[r_cnt[IDX_W-1:0]] <= w_rec;
        end
    end

    // The read port follows the depth the parser will have next cycle, so the
    // top entry is already registered when a pop needs it.
    always_comb begin
        w_depth_nx = r_depth;
        if (i_cmd.load && i_begin_doc) begin
            w_depth_nx = '0;
        end else if (i_cmd.step) begin
            w_depth_nx = n_depth;
        end
    end

    assign w_we      = i_cmd.step && w_push;
    assign w_wr_addr = r_depth[AW-1:0];
    assign w_rd_addr = AW'(w_depth_nx - DW'(1));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_stack[w_wr_addr] <= r_item;
        end
        if (w_we && (w_wr_addr == w_rd_addr)) begin
            r_top <= r_item;
        end else begin
            r_top <= r_stack[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.drain) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.drain) begin
            r_out_rec  <= r_buf[i_cmd.drain_idx];
            r_out_last <= i_cmd.drain_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_rec      = r_out_rec;
    assign o_out_last     = r_out_last;
    assign o_sts.halted   = r_halted;
    assign o_sts.stop     = w_stop;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.ev_cnt   = r_cnt;

endmodule

`default_nettype wire

FILE: sv/json_char_event_tokenizer_unit.sv
// ============================================================================
// json_char_event_tokenizer_unit: lenient JSON character tokenizer
// Takes one text character per transaction and emits parse events (member,
// name and value characters, array marks, object push and pop, ok, fail).
// ============================================================================
//
//  Channel   Dir  Handshake      Payload
//  i_char    in   valid/ready    char_code[7:0], begin_doc
//  o_event   out  valid/ready    event_code[3:0], event_char[7:0], depth[5:0],
//                                is_array, last
//
// A character is accepted in the idle state, then the parser runs up to
// MAX_STEPS transitions on it, then its events move to the output register
// one at a time; a character with no events goes straight back to idle.
// While the parser is halted a character passes through the step state with
// no transition and skips the drain. A pop reads the array flag stack from a
// registered read port that follows the depth the parser will have next.
// Reset is synchronous and active low and leaves the parser in its skip
// state; the stack memory needs no clearing, since only pushed entries are
// popped. A stalled output holds the controller in its drain state, and the
// next character is accepted while the final event still waits for its sink.
//
`default_nettype none

module json_char_event_tokenizer_unit #(
    parameter int unsigned MAX_DEPTH = jcet_pkg::MAX_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    jcet_char_if.sink   i_char,
    jcet_event_if.source o_event
);
    import jcet_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_sts    w_sts;
    logic       w_in_ready;
    logic       w_out_valid;
    t_event_rec w_out_rec;
    logic       w_out_last;

    // The controller owns the input handshake and the sequencing.
    jcet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_char.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the parser state, the stack and the output register.
    jcet_dp #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_char_code (i_char.char_code),
        .i_begin_doc (i_char.begin_doc),
        .i_out_ready (o_event.ready),
        .o_out_valid (w_out_valid),
        .o_out_rec   (w_out_rec),
        .o_out_last  (w_out_last)
    );

    assign i_char.ready       = w_in_ready;
    assign o_event.valid      = w_out_valid;
    assign o_event.event_code = w_out_rec.code;
    assign o_event.event_char = w_out_rec.ch;
    assign o_event.depth      = w_out_rec.depth;
    assign o_event.is_array   = w_out_rec.is_array;
    assign o_event.last       = w_out_last;

`ifndef SYNTHESIS
    // A new document always starts unhalted.
    a_begin_clears_halt : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_char.valid && i_char.ready && i_char.begin_doc) |=> !w_sts.halted)
        else $error("begin_doc did not clear the halted flag");

    // An event is moved out only when the output register can take it.
    a_drain_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.drain |-> w_sts.out_free)
        else $error("event moved into a busy output register");

    // The event buffer never counts more than four events.
    a_event_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.ev_cnt <= CNT_W'(MAX_EVENTS))
        else $error("event buffer count out of range");

    // A character is never accepted while a transition is in progress.
    a_no_accept_in_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> !i_char.ready)
        else $error("input accepted during a parser transition");
`endif

endmodule

`default_nettype wire

FILE: test/json_char_event_tokenizer_unit_tb.sv
// ============================================================================
// json_char_event_tokenizer_unit_tb: self-checking bench for the tokenizer
// Streams directed and random JSON-like texts into the character channel,
// predicts every parse event with a behavioral tokenizer of its own, and
// compares each event transaction field by field under random stalls.
// ============================================================================

module json_char_event_tokenizer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import jcet_pkg::*;

    localparam int unsigned MAX_NEST     = MAX_DEPTH_DEF;
    localparam int          RANDOM_CHARS = 80;
    localparam int          STALL_LIMIT  = 500;
    localparam int          LINGER       = 40;
    localparam int          REPORT_MAX   = 10;

    // One predicted event, in the order the output channel carries its fields.
    typedef struct packed {
        t_event              code;
        logic [CHAR_W-1:0]   ch;
        logic [DEPTH_W-1:0]  depth;
        logic                is_arr;
        logic                last;
    } t_tok_event;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jcet_char_if  char_if();
    jcet_event_if event_if();

    json_char_event_tokenizer_unit #(
        .MAX_DEPTH (MAX_NEST)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .o_event (event_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Tokenizer state as the bench sees it. Only pushed stack entries are
    // ever read back, so the flag stack is never cleared.
    // ------------------------------------------------------------------------
    t_pstate             tok_state;
    logic                tok_in_array;
    logic                tok_item_flag;
    logic [DEPTH_W-1:0]  tok_depth;
    logic                tok_halted;
    logic                flag_stack [MAX_NEST];

    // Outcome of one transition of the parser automaton.
    t_pstate             step_next;
    t_act                step_act;
    t_stack_op           step_op;

    t_tok_event          char_events[$];     // events of the character at hand
    t_tok_event          pending_events[$];  // predicted, not yet seen on o_event
    logic [CHAR_W-1:0]   doc_text[$];        // text being built for sending

    int mismatch_count = 0;
    int chars_sent     = 0;
    int docs_sent      = 0;
    int events_checked = 0;
    int ok_seen        = 0;
    int fail_seen      = 0;
    int deepest        = 0;
    int burst_left     = 0;
    int max_gap        = 0;
    int idle_cycles    = 0;

    logic [15:0] sink_pattern;
    int          sink_age;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic is_delim(input logic [CHAR_W-1:0] c);
        return c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE ||
               c == CH_LBRACE || c == CH_LBRACK;
    endfunction

    function automatic void clear_parser();
        tok_state     = PS_SKIP;
        tok_in_array  = 1'b0;
        tok_item_flag = 1'b0;
        tok_depth     = '0;
        tok_halted    = 1'b0;
    endfunction

    function automatic void go_to(input t_pstate s, input t_act a);
        step_next = s;
        step_act  = a;
    endfunction

    // An event snapshots depth and array flag as they stand when it is made.
    // A character can make at most MAX_EVENTS of them; any further are lost.
    function automatic void log_event(input t_event code, input logic [CHAR_W-1:0] ch);
        t_tok_event ev;
        if (char_events.size() >= MAX_EVENTS)
            return;
        ev.code   = code;
        ev.ch     = ch;
        ev.depth  = tok_depth;
        ev.is_arr = tok_in_array;
        ev.last   = 1'b0;
        char_events.push_back(ev);
        if (int'(tok_depth) > deepest)
            deepest = tok_depth;
    endfunction

    // Runs one accepted character through the automaton. A pausing transition
    // keeps the character and looks at it again in the new state.
    function automatic void tokenize_char(input logic [CHAR_W-1:0] c, input logic restart);
        logic ends_value;
        logic blank;
        int   s;
        char_events.delete();
        if (restart)
            clear_parser();
        if (tok_halted)
            return;
        ends_value = c == CH_QUOTE || c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE;
        blank      = is_blank(c);
        for (s = 0; s < MAX_STEPS; s++) begin
            step_next = PS_SKIP;
            step_act  = ACT_FAIL;
            step_op   = OP_NONE;
            case (tok_state)
                PS_SKIP: begin
                    if (c == CH_LBRACE) go_to(PS_OPEN, ACT_PAUSE);
                    else if (c == CH_NUL) step_act = ACT_OK;
                    else go_to(PS_SKIP, ACT_NEXT);
                end
                PS_OPEN: begin
                    if (c == CH_LBRACE) begin
                        go_to(PS_OPEN, ACT_NEXT);
                        step_op = OP_PUSH;
                    end else if (blank) go_to(PS_OPEN, ACT_NEXT);
                    else if (c == CH_QUOTE) go_to(PS_IBEG, ACT_PAUSE);
                end
                PS_IBEG: begin
                    if (c == CH_QUOTE) go_to(PS_NQUOT, ACT_NEXT);
                end
                PS_NQUOT: go_to(PS_NBEG, ACT_PAUSE);
                PS_NBEG: begin
                    if (c == CH_QUOTE) go_to(PS_NEND, ACT_PAUSE);
                    else if (c != CH_NUL) go_to(PS_NBEG, ACT_NEXT);
                end
                PS_NEND: begin
                    if (c == CH_QUOTE || blank) go_to(PS_NEND, ACT_NEXT);
                    else if (c == CH_COLON) go_to(PS_ASSIGN, ACT_NEXT);
                end
                PS_ASSIGN: begin
                    if (blank) go_to(PS_ASSIGN, ACT_NEXT);
                    else if (c == CH_LBRACE) go_to(PS_OPEN, ACT_PAUSE);
                    else if (c == CH_LBRACK) go_to(PS_ABEG, ACT_PAUSE);
                    else if (c == CH_QUOTE) go_to(PS_VQUOT, ACT_NEXT);
                    else go_to(PS_VBEG, ACT_PAUSE);
                end
                PS_ABEG: begin
                    if (c == CH_LBRACK || blank) go_to(PS_ABEG, ACT_NEXT);
                    else if (c == CH_LBRACE) go_to(PS_OPEN, ACT_PAUSE);
                    else if (c == CH_QUOTE) go_to(PS_VQUOT, ACT_NEXT);
                    else if (ends_value) go_to(PS_VEND, ACT_PAUSE);
                    else go_to(PS_VBEG, ACT_PAUSE);
                end
                PS_VQUOT: go_to(PS_VBEG, ACT_PAUSE);
                PS_VBEG: begin
                    if (ends_value) go_to(PS_VEND, ACT_PAUSE);
                    else if (c != CH_NUL) go_to(PS_VBEG, ACT_NEXT);
                end
                PS_VEND: begin
                    if (c == CH_QUOTE || blank) go_to(PS_VEND, ACT_NEXT);
                    else if (c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE)
                        go_to(PS_IEND, ACT_PAUSE);
                end
                PS_IEND: begin
                    if (c == CH_COMMA) begin
                        if (tok_in_array) go_to(PS_IRET, ACT_PAUSE);
                        else go_to(PS_IEND, ACT_NEXT);
                    end else if (blank) go_to(PS_IEND, ACT_NEXT);
                    else if (c == CH_QUOTE) go_to(PS_IBEG, ACT_PAUSE);
                    else if (c == CH_RBRACK) go_to(PS_AEND, ACT_PAUSE);
                    else if (c == CH_RBRACE) go_to(PS_CLOSE, ACT_PAUSE);
                end
                PS_IRET: begin
                    if (c == CH_COMMA || blank) go_to(PS_IRET, ACT_NEXT);
                    else if (c == CH_LBRACE) go_to(PS_OPEN, ACT_PAUSE);
                    else if (c == CH_QUOTE) go_to(PS_VQUOT, ACT_NEXT);
                    else go_to(PS_VBEG, ACT_PAUSE);
                end
                PS_AEND: begin
                    if (c == CH_RBRACK || blank) go_to(PS_AEND, ACT_NEXT);
                    else if (c == CH_COMMA || c == CH_RBRACE) go_to(PS_IEND, ACT_PAUSE);
                end
                PS_CLOSE: begin
                    if (c == CH_RBRACE) begin
                        go_to(PS_CLOSE, ACT_NEXT);
                        step_op = OP_POP;
                    end else if (blank) go_to(PS_CLOSE, ACT_NEXT);
                    else if (c == CH_RBRACK) go_to(PS_AEND, ACT_PAUSE);
                    else if (c == CH_COMMA) go_to(PS_IEND, ACT_PAUSE);
                    else go_to(PS_SKIP, ACT_PAUSE);
                end
                default: ;
            endcase

            if (step_act == ACT_OK || step_act == ACT_FAIL) begin
                log_event((step_act == ACT_OK) ? EV_OK : EV_FAIL, CH_NUL);
                tok_halted = 1'b1;
                break;
            end
            tok_state = step_next;

            if (step_act == ACT_PAUSE) begin
                case (step_next)
                    PS_ABEG: begin
                        tok_in_array  = 1'b1;
                        tok_item_flag = 1'b1;
                        log_event(EV_ARRAY_MARK, CH_NUL);
                    end
                    PS_AEND: tok_in_array = 1'b0;
                    PS_NBEG: begin
                        tok_item_flag = 1'b0;
                        log_event(EV_MEMBER, CH_NUL);
                    end
                    PS_IRET: begin
                        tok_item_flag = tok_in_array;
                        log_event(EV_ELEMENT, CH_NUL);
                    end
                    PS_NEND: log_event(EV_NAME_DONE, CH_NUL);
                    PS_VBEG: log_event(EV_VALUE_START, CH_NUL);
                    PS_VEND: log_event(EV_VALUE_DONE, CH_NUL);
                    default: ;
                endcase
            end else if (step_next == PS_NBEG) begin
                log_event(EV_NAME_CHAR, c);
            end else if (step_next == PS_VBEG) begin
                log_event(EV_VALUE_CHAR, c);
            end

            if (step_op == OP_PUSH) begin
                if (tok_depth >= MAX_NEST) begin
                    log_event(EV_FAIL, CH_NUL);
                    tok_halted = 1'b1;
                    break;
                end
                flag_stack[tok_depth] = tok_item_flag;
                tok_depth             = tok_depth + 1'b1;
                tok_in_array          = 1'b0;
                log_event(EV_PUSH, CH_NUL);
            end else if (step_op == OP_POP) begin
                if (tok_depth == 0 || tok_depth > MAX_NEST) begin
                    log_event(EV_FAIL, CH_NUL);
                    tok_halted = 1'b1;
                    break;
                end
                tok_depth     = tok_depth - 1'b1;
                tok_in_array  = flag_stack[tok_depth];
                tok_item_flag = tok_in_array;
                log_event(EV_POP, CH_NUL);
            end

            if (step_act == ACT_NEXT)
                break;
        end

        if (char_events.size() > 0)
            char_events[char_events.size() - 1].last = 1'b1;
        foreach (char_events[i])
            pending_events.push_back(char_events[i]);
    endfunction

    task automatic record_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Character sender. It runs in bursts of random length; between bursts
    // valid drops for a random gap. A max_gap of zero gives back-to-back
    // transactions. The expectation is formed at the edge of acceptance.
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic restart);
        int gap;
        if (burst_left == 0) begin
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0) begin
                char_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        char_if.valid     <= 1'b1;
        char_if.char_code <= c;
        char_if.begin_doc <= restart;
        @(posedge i_clk);
        while (!char_if.ready)
            @(posedge i_clk);
        burst_left--;
        chars_sent++;
        tokenize_char(c, restart);
    endtask

    task automatic send_text(input string s, input logic restart);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i], restart && i == 0);
    endtask

    // Holds the sender off until every predicted event has been seen. Each check
    // follows a clock edge, so valid never drops and rises in one time step.
    task automatic drain_events();
        char_if.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge i_clk);
        while (pending_events.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Event receiver and checker. Ready follows a rotating 16-bit pattern that
    // is redrawn whenever sink_age wraps; a quarter of the draws never stall.
    // ------------------------------------------------------------------------
    task automatic check_event();
        t_tok_event want;
        if (pending_events.size() == 0) begin
            record_mismatch($sformatf("unexpected event code=%0d char=%02h depth=%0d",
                                      event_if.event_code, event_if.event_char,
                                      event_if.depth));
            return;
        end
        want = pending_events.pop_front();
        events_checked++;
        if (want.code == EV_OK)
            ok_seen++;
        if (want.code == EV_FAIL)
            fail_seen++;
        if (event_if.event_code !== want.code || event_if.event_char !== want.ch ||
            event_if.depth !== want.depth || event_if.is_array !== want.is_arr ||
            event_if.last !== want.last)
            record_mismatch($sformatf(
                "expected code=%0d char=%02h depth=%0d arr=%0b last=%0b, got %0d %02h %0d %0b %0b",
                want.code, want.ch, want.depth, want.is_arr, want.last,
                event_if.event_code, event_if.event_char, event_if.depth,
                event_if.is_array, event_if.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            event_if.ready <= 1'b0;
            sink_pattern   <= 16'hFFFF;
            sink_age       <= 0;
        end else begin
            if (event_if.valid && event_if.ready)
                check_event();
            if (sink_age == 63) begin
                sink_age     <= 0;
                sink_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                             : (16'($urandom) | 16'h0001);
            end else begin
                sink_age     <= sink_age + 1;
                sink_pattern <= {sink_pattern[0], sink_pattern[15:1]};
            end
            event_if.ready <= sink_pattern[0];
        end
    end

    // Watchdog: the run dies if neither channel moves for too long.
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (char_if.valid && char_if.ready) ||
                (event_if.valid && event_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no transaction for %0d cycles.", STALL_LIMIT);
        $display("** json_char_event_tokenizer_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Random text builders. They append to doc_text. Objects nest at most
    // three deep; arrays hold plain values, quoted values and objects.
    // ------------------------------------------------------------------------
    function automatic logic [CHAR_W-1:0] blank_char();
        case ($urandom_range(0, 3))
            0: return CH_TAB;
            1: return CH_LF;
            2: return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic void add_blanks();
        if ($urandom_range(0, 3) == 0)
            doc_text.push_back(blank_char());
    endfunction

    // Name characters may be any nonzero code but the quote; value characters
    // are printable and steer clear of the delimiters.
    function automatic logic [CHAR_W-1:0] text_char(input logic in_name);
        logic [CHAR_W-1:0] c;
        do begin
            c = in_name ? CHAR_W'($urandom_range(1, 255)) : CHAR_W'($urandom_range(8'h21, 8'h7E));
        end while (c == CH_QUOTE || (!in_name && is_delim(c)));
        return c;
    endfunction

    function automatic void add_value(input int lvl, input logic in_list);
        int kind;
        int n;
        int i;
        kind = $urandom_range(0, (lvl < 2) ? 3 : 1);
        if (in_list && kind == 3)
            kind = 2;
        case (kind)
            0: repeat ($urandom_range(1, 3)) doc_text.push_back(text_char(1'b0));
            1: begin
                doc_text.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 3)) doc_text.push_back(text_char(1'b0));
                doc_text.push_back(CH_QUOTE);
            end
            2: add_object(lvl + 1);
            default: begin
                doc_text.push_back(CH_LBRACK);
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++) begin
                    if (i > 0)
                        doc_text.push_back(CH_COMMA);
                    add_blanks();
                    add_value(lvl, 1'b1);
                end
                doc_text.push_back(CH_RBRACK);
            end
        endcase
    endfunction

    function automatic void add_object(input int lvl);
        int members;
        int m;
        members = $urandom_range(1, (lvl == 0) ? 3 : 2);
        doc_text.push_back(CH_LBRACE);
        for (m = 0; m < members; m++) begin
            if (m > 0)
                doc_text.push_back(CH_COMMA);
            add_blanks();
            doc_text.push_back(CH_QUOTE);
            repeat ($urandom_range(1, 3)) doc_text.push_back(text_char(1'b1));
            doc_text.push_back(CH_QUOTE);
            add_blanks();
            doc_text.push_back(CH_COLON);
            add_blanks();
            add_value(lvl, 1'b0);
            add_blanks();
        end
        doc_text.push_back(CH_RBRACE);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // A complete document behind a byte of leading junk: members, nested
    // object, an empty array, an array opening with a comma, elements, push,
    // pop, and ok on end of text after the last brace. The trailing character
    // arrives while halted and must make no event.
    task automatic test_full_document();
        docs_sent++;
        max_gap = 0;
        send_char(8'hFF, 1'b1);
        send_text("{\"a\": [],\"b\":[,7,{\"c\":\"d\"}]}", 1'b0);
        send_char(CH_NUL, 1'b0);
        send_char("z", 1'b0);
        drain_events();
    endtask

    // End of text inside a name must fail; the name carries the top code.
    task automatic test_unterminated_name();
        docs_sent++;
        max_gap = 3;
        send_text("{\"a", 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(CH_NUL, 1'b0);
        drain_events();
    endtask

    // End of text inside a quoted value must fail as well.
    task automatic test_unterminated_value();
        docs_sent++;
        max_gap = 2;
        send_text("{\"a\":\"b", 1'b1);
        send_char(CH_NUL, 1'b0);
        drain_events();
    endtask

    // A closing brace with nothing left on the stack fails.
    task automatic test_stack_underflow();
        docs_sent++;
        max_gap = 0;
        send_text("{\"a\":1}}", 1'b1);
        drain_events();
    endtask

    // Opening braces up to the stack limit push; the next one fails, and the
    // end of text after it is ignored.
    task automatic test_stack_overflow();
        int i;
        docs_sent++;
        max_gap = 1;
        for (i = 0; i <= MAX_NEST; i++)
            send_char(CH_LBRACE, i == 0);
        send_char(CH_NUL, 1'b0);
        drain_events();
    endtask

    // Mostly well-formed documents with random content and spacing, plus
    // truncated texts, corrupted characters, restarts in mid-document and
    // plain noise over the whole code range.
    task automatic test_random_documents();
        int sent;
        int kind;
        int idx;
        int restart_at;
        int i;
        logic fresh;
        logic [CHAR_W-1:0] c;
        sent = 0;
        while (sent < RANDOM_CHARS) begin
            doc_text.delete();
            kind       = $urandom_range(0, 9);
            restart_at = -1;
            max_gap    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (kind == 9) begin
                repeat ($urandom_range(4, 12)) doc_text.push_back(CHAR_W'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(0, 2)) begin
                    do
                        c = CHAR_W'($urandom_range(1, 255));
                    while (c == CH_LBRACE);
                    doc_text.push_back(c);
                end
                add_object(0);
                add_blanks();
                doc_text.push_back(CH_NUL);
                idx = $urandom_range(1, doc_text.size() - 1);
                if (kind == 6) begin
                    doc_text = doc_text[0:idx-1];
                    doc_text.push_back(CH_NUL);
                end else if (kind == 7) begin
                    doc_text[idx] = CHAR_W'($urandom_range(0, 255));
                end else if (kind == 8) begin
                    restart_at = idx;
                end
            end
            // Now and then a document starts without a restart, so it lands
            // on whatever state the previous one left behind.
            fresh = $urandom_range(0, 7) != 0;
            docs_sent++;
            for (i = 0; i < doc_text.size(); i++)
                send_char(doc_text[i], (i == 0) ? fresh : (i == restart_at));
            sent += doc_text.size();
            if ($urandom_range(0, 2) == 0)
                drain_events();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        char_if.valid      = 1'b0;
        char_if.char_code  = CH_NUL;
        char_if.begin_doc  = 1'b0;
        clear_parser();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_full_document();
        test_unterminated_name();
        test_unterminated_value();
        test_stack_underflow();
        test_stack_overflow();
        test_random_documents();

        drain_events();
        repeat (LINGER) @(posedge i_clk);
        if (pending_events.size() != 0)
            record_mismatch($sformatf("%0d predicted events never arrived",
                                      pending_events.size()));

        $display("Run covered %0d characters in %0d documents, nesting up to depth %0d.",
                 chars_sent, docs_sent, deepest);
        $display("%0d events checked (%0d ok, %0d fail), %0d mismatches.",
                 events_checked, ok_seen, fail_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("** json_char_event_tokenizer_unit: PASSED **");
        else
            $display("** json_char_event_tokenizer_unit: FAILED **");
        $finish;
    end

endmodule
